[rtl/core/dda_line_rasterizer_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_CORE_ASSERT_SVH
`define DDA_LINE_RASTERIZER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define DLR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dlr assertion failed");

// Next-cycle implication, disabled while reset is held
`define DLR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dlr assertion failed");

`endif

[rtl/core/dlr_pkg.sv]
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared constants, codes and types of the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dlr_pkg;

    localparam int SCREEN_W   = 10;
    localparam int QUAD_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MAX_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_MAX_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUADRANT     = 2'd2;

    localparam logic [SCREEN_W-1:0] SCREEN_MAX_RST = 10'd599;

    localparam logic [QUAD_W-1:0] QUAD_1 = 3'd1;
    localparam logic [QUAD_W-1:0] QUAD_2 = 3'd2;
    localparam logic [QUAD_W-1:0] QUAD_3 = 3'd3;
    localparam logic [QUAD_W-1:0] QUAD_4 = 3'd4;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Pixel handed from the engine to the output stage
    typedef struct packed {
        logic pend;
        logic valid_res;
        logic last;
    } t_emit_req;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
    } t_axis_sign;

    // Unknown quadrant codes fall back to quadrant 1
    function automatic t_axis_sign quad_sign(input logic [QUAD_W-1:0] quad);
        t_axis_sign s;
        unique case (quad)
            QUAD_2: begin
                s.neg_x = 1'b1;
                s.neg_y = 1'b1;
            end
            QUAD_3: begin
                s.neg_x = 1'b1;
                s.neg_y = 1'b0;
            end
            QUAD_4: begin
                s.neg_x = 1'b0;
                s.neg_y = 1'b0;
            end
            default: begin
                s.neg_x = 1'b0;
                s.neg_y = 1'b1;
            end
        endcase
        return s;
    endfunction

endpackage

[rtl/core/dlr_cmd_if.sv]
// ----------------------------------------------------------------------------
// dlr_cmd_if
// Command channel: start a line or advance one pixel.
// ----------------------------------------------------------------------------
interface dlr_cmd_if #(
    parameter int COORD_BITS = 10
);
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;

    modport source (output valid, op, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, op, x_start, y_start, x_end, y_end, output ready);
endinterface

[rtl/core/dlr_pix_if.sv]
// ----------------------------------------------------------------------------
// dlr_pix_if
// Pixel channel: one screen pixel per transaction.
// ----------------------------------------------------------------------------
interface dlr_pix_if #(
    parameter int COORD_BITS = 10
);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_BITS+1:0]   pixel_x;
    logic signed [COORD_BITS+1:0]   pixel_y;
    logic                           valid_res;
    logic                           last;

    modport source (output valid, pixel_x, pixel_y, valid_res, last, input ready);
    modport sink   (input valid, pixel_x, pixel_y, valid_res, last, output ready);
endinterface

[rtl/core/dlr_front.sv]
// ----------------------------------------------------------------------------
// dlr_front
// Accepts commands, works out deltas and step count, and queues them.
// ----------------------------------------------------------------------------
module dlr_front
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    dlr_cmd_if.sink                      i_cmd,
    output logic                         o_q_valid,
    input  logic                         i_q_pop,
    output logic [5*COORD_BITS+2:0]      o_q_data
);
    localparam int C   = COORD_BITS;
    localparam int E_W = 5 * COORD_BITS + 3;

    logic signed [C:0]   dx;
    logic signed [C:0]   dy;
    logic [C:0]          ndx;
    logic [C:0]          ndy;
    logic [C-1:0]        adx;
    logic [C-1:0]        ady;
    logic [C-1:0]        steps;
    logic [E_W-1:0]      entry;
    logic                push;

    logic [E_W-1:0]      r_mem [2];
    logic                r_wp;
    logic                r_rp;
    logic [1:0]          r_cnt;
    logic                n_wp;
    logic                n_rp;
    logic [1:0]          n_cnt;

    assign dx  = {i_cmd.x_end[C-1], i_cmd.x_end} - {i_cmd.x_start[C-1], i_cmd.x_start};
    assign dy  = {i_cmd.y_end[C-1], i_cmd.y_end} - {i_cmd.y_start[C-1], i_cmd.y_start};
    assign ndx = -dx;
    assign ndy = -dy;
    assign adx = dx[C] ? ndx[C-1:0] : dx[C-1:0];
    assign ady = dy[C] ? ndy[C-1:0] : dy[C-1:0];
    assign steps = (adx > ady) ? adx : ady;

    assign entry = {i_cmd.op, i_cmd.x_start, i_cmd.y_start, adx, ady, dx[C], dy[C], steps};

    assign i_cmd.ready = (r_cnt != 2'd2);
    assign push        = i_cmd.valid && i_cmd.ready;
    assign o_q_valid   = (r_cnt != 2'd0);
    assign o_q_data    = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (push) begin
            n_wp = ~r_wp;
        end
        if (i_q_pop) begin
            n_rp = ~r_rp;
        end
        case ({push, i_q_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= entry;
        end
    end

endmodule

[rtl/core/dlr_engine.sv]
// ----------------------------------------------------------------------------
// dlr_engine
// Line state: restoring divider for the increments, position stepping.
// ----------------------------------------------------------------------------
module dlr_engine
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_q_valid,
    output logic                                        o_q_pop,
    input  logic [5*COORD_BITS+2:0]                     i_q_data,
    output t_emit_req                                   o_emit,
    input  logic                                        i_emit_take,
    output logic signed [COORD_BITS+FRAC_BITS+1:0]      o_pos_x,
    output logic signed [COORD_BITS+FRAC_BITS+1:0]      o_pos_y
);
    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int PW    = COORD_BITS + FRAC_BITS + 2;
    localparam int IW    = FRAC_BITS + 2;
    localparam int QW    = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } t_eng_state;

    logic                e_op;
    logic signed [C-1:0] e_x1;
    logic signed [C-1:0] e_y1;
    logic [C-1:0]        e_adx;
    logic [C-1:0]        e_ady;
    logic                e_neg_x;
    logic                e_neg_y;
    logic [C-1:0]        e_steps;
    logic                slot_free;

    t_eng_state           r_state,   n_state;
    logic signed [PW-1:0] r_pos_x,   n_pos_x;
    logic signed [PW-1:0] r_pos_y,   n_pos_y;
    logic signed [IW-1:0] r_inc_x,   n_inc_x;
    logic signed [IW-1:0] r_inc_y,   n_inc_y;
    logic [C-1:0]         r_steps,   n_steps;
    logic                 r_active,  n_active;
    t_emit_req            r_emit,    n_emit;
    logic [CNT_W-1:0]     r_div_cnt, n_div_cnt;
    logic [C:0]           r_rem_x,   n_rem_x;
    logic [C:0]           r_rem_y,   n_rem_y;
    logic [QW-1:0]        r_q_x,     n_q_x;
    logic [QW-1:0]        r_q_y,     n_q_y;
    logic [C-1:0]         r_div_s,   n_div_s;
    logic                 r_neg_x,   n_neg_x;
    logic                 r_neg_y,   n_neg_y;

    assign {e_op, e_x1, e_y1, e_adx, e_ady, e_neg_x, e_neg_y, e_steps} = i_q_data;

    assign slot_free = !r_emit.pend || i_emit_take;
    assign o_q_pop   = (r_state == ST_IDLE) && i_q_valid && slot_free;
    assign o_emit    = r_emit;
    assign o_pos_x   = r_pos_x;
    assign o_pos_y   = r_pos_y;

    always_comb begin
        logic          ge_x;
        logic          ge_y;
        logic [C:0]    sub_x;
        logic [C:0]    sub_y;
        logic [QW-1:0] qf_x;
        logic [QW-1:0] qf_y;
        logic [IW-1:0] qe_x;
        logic [IW-1:0] qe_y;
        logic          is_last;

        n_state   = r_state;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_inc_x   = r_inc_x;
        n_inc_y   = r_inc_y;
        n_steps   = r_steps;
        n_active  = r_active;
        n_emit    = r_emit;
        n_div_cnt = r_div_cnt;
        n_rem_x   = r_rem_x;
        n_rem_y   = r_rem_y;
        n_q_x     = r_q_x;
        n_q_y     = r_q_y;
        n_div_s   = r_div_s;
        n_neg_x   = r_neg_x;
        n_neg_y   = r_neg_y;

        ge_x    = r_rem_x >= {1'b0, r_div_s};
        ge_y    = r_rem_y >= {1'b0, r_div_s};
        sub_x   = ge_x ? (r_rem_x - {1'b0, r_div_s}) : r_rem_x;
        sub_y   = ge_y ? (r_rem_y - {1'b0, r_div_s}) : r_rem_y;
        qf_x    = {r_q_x[QW-2:0], ge_x};
        qf_y    = {r_q_y[QW-2:0], ge_y};
        qe_x    = {1'b0, qf_x};
        qe_y    = {1'b0, qf_y};
        is_last = (r_steps == C'(1));

        if (i_emit_take) begin
            n_emit.pend = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (o_q_pop) begin
                    if (e_op == OP_START) begin
                        n_pos_x = PW'(e_x1) <<< F;
                        n_pos_y = PW'(e_y1) <<< F;
                        n_steps = e_steps;
                        if (e_steps == '0) begin
                            // zero-length line: one pixel, no division
                            n_inc_x  = '0;
                            n_inc_y  = '0;
                            n_active = 1'b0;
                            n_emit   = '{pend: 1'b1, valid_res: 1'b1, last: 1'b1};
                        end else begin
                            n_active  = 1'b0;
                            n_rem_x   = {1'b0, e_adx};
                            n_rem_y   = {1'b0, e_ady};
                            n_div_s   = e_steps;
                            n_neg_x   = e_neg_x;
                            n_neg_y   = e_neg_y;
                            n_q_x     = '0;
                            n_q_y     = '0;
                            n_div_cnt = '0;
                            n_state   = ST_DIV;
                        end
                    end else if (r_active) begin
                        n_pos_x  = r_pos_x + PW'(r_inc_x);
                        n_pos_y  = r_pos_y + PW'(r_inc_y);
                        n_steps  = r_steps - C'(1);
                        n_active = !is_last;
                        n_emit   = '{pend: 1'b1, valid_res: 1'b1, last: is_last};
                    end else begin
                        n_emit = '{pend: 1'b1, valid_res: 1'b0, last: 1'b0};
                    end
                end
            end
            ST_DIV: begin
                // one quotient bit per axis each cycle, integer bit first
                n_rem_x   = {sub_x[C-1:0], 1'b0};
                n_rem_y   = {sub_y[C-1:0], 1'b0};
                n_q_x     = qf_x;
                n_q_y     = qf_y;
                n_div_cnt = r_div_cnt + CNT_W'(1);
                if (r_div_cnt == CNT_W'(F)) begin
                    n_inc_x  = r_neg_x ? -qe_x : qe_x;
                    n_inc_y  = r_neg_y ? -qe_y : qe_y;
                    n_active = 1'b1;
                    n_emit   = '{pend: 1'b1, valid_res: 1'b1, last: 1'b0};
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_inc_x  <= '0;
            r_inc_y  <= '0;
            r_steps  <= '0;
            r_active <= 1'b0;
            r_emit   <= '0;
        end else begin
            r_state  <= n_state;
            r_pos_x  <= n_pos_x;
            r_pos_y  <= n_pos_y;
            r_inc_x  <= n_inc_x;
            r_inc_y  <= n_inc_y;
            r_steps  <= n_steps;
            r_active <= n_active;
            r_emit   <= n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div_cnt <= n_div_cnt;
        r_rem_x   <= n_rem_x;
        r_rem_y   <= n_rem_y;
        r_q_x     <= n_q_x;
        r_q_y     <= n_q_y;
        r_div_s   <= n_div_s;
        r_neg_x   <= n_neg_x;
        r_neg_y   <= n_neg_y;
    end

endmodule

[rtl/core/dlr_emit.sv]
// ----------------------------------------------------------------------------
// dlr_emit
// Rounds the position, mirrors and centers it, and holds the output pixel.
// ----------------------------------------------------------------------------
module dlr_emit
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  t_emit_req                                   i_emit,
    output logic                                        o_emit_take,
    input  logic signed [COORD_BITS+FRAC_BITS+1:0]      i_pos_x,
    input  logic signed [COORD_BITS+FRAC_BITS+1:0]      i_pos_y,
    input  logic [SCREEN_W-1:0]                         i_screen_max_x,
    input  logic [SCREEN_W-1:0]                         i_screen_max_y,
    input  logic [QUAD_W-1:0]                           i_quad,
    dlr_pix_if.source                                   o_pix
);
    localparam int F     = FRAC_BITS;
    localparam int PW    = COORD_BITS + FRAC_BITS + 2;
    localparam int PIX_W = COORD_BITS + 2;
    localparam int CW    = PIX_W + SCREEN_W;
    localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

    logic [PW-1:0]    sum_x;
    logic [PW-1:0]    sum_y;
    logic [PIX_W-1:0] rnd_x;
    logic [PIX_W-1:0] rnd_y;
    logic [CW-1:0]    cxw;
    logic [CW-1:0]    cyw;
    logic [PIX_W-1:0] cx;
    logic [PIX_W-1:0] cy;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] py;
    t_axis_sign       sgn;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_px;
    logic [PIX_W-1:0] r_py;
    logic             r_vres;
    logic             r_last;

    // half away from zero: negative values add one less before the floor shift
    assign sum_x = i_pos_x + HALF - PW'(i_pos_x[PW-1]);
    assign sum_y = i_pos_y + HALF - PW'(i_pos_y[PW-1]);
    assign rnd_x = sum_x[PW-1:F];
    assign rnd_y = sum_y[PW-1:F];

    assign cxw = CW'(i_screen_max_x >> 1);
    assign cyw = CW'(i_screen_max_y >> 1);
    assign cx  = cxw[PIX_W-1:0];
    assign cy  = cyw[PIX_W-1:0];
    assign sgn = quad_sign(i_quad);
    assign px  = sgn.neg_x ? (cx - rnd_x) : (cx + rnd_x);
    assign py  = sgn.neg_y ? (cy - rnd_y) : (cy + rnd_y);

    assign o_emit_take = i_emit.pend && (!r_out_valid || o_pix.ready);

    assign o_pix.valid     = r_out_valid;
    assign o_pix.pixel_x   = r_px;
    assign o_pix.pixel_y   = r_py;
    assign o_pix.valid_res = r_vres;
    assign o_pix.last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_emit_take) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_emit_take) begin
            r_px   <= i_emit.valid_res ? px : '0;
            r_py   <= i_emit.valid_res ? py : '0;
            r_vres <= i_emit.valid_res;
            r_last <= i_emit.last;
        end
    end

endmodule

[rtl/core/dda_line_rasterizer_core.sv]
// DDA line rasterizer. A start command (op 0) takes two endpoints, finds the
// step count as the larger absolute delta and divides each delta by it into a
// signed increment with FRAC_BITS fraction bits; it then emits the first pixel.
// Each advance command (op 1) adds the increments and emits the next pixel,
// with last set on the endpoint; an advance with no line active returns a
// transaction with valid_res low and zero fields. Pixels are rounded half away
// from zero, mirrored per quadrant_select and offset by half the screen size,
// using the register values current when the pixel leaves the engine.
// Advance commands and zero-length starts run one per clock while the pixel
// output accepts, set by the single-add position update in the engine. A start
// with nonzero length holds the engine in the restoring divider (both axes in
// parallel, one quotient bit per cycle), then emits. A two-entry command
// queue and a registered output stage let either side stall independently.
// A command passes from its queue entry through the engine's emit request,
// after any division, into the registered output.
// Configuration: index 0 screen_max_x, 1 screen_max_y, 2 quadrant_select; a
// write beyond these is ignored.
// ----------------------------------------------------------------------------
// dda_line_rasterizer_core
// Top level: configuration registers, command front end, engine, output stage.
// ----------------------------------------------------------------------------
module dda_line_rasterizer_core
    import dlr_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dlr_cmd_if.sink               i_cmd,
    dlr_pix_if.source             o_pix
);
    localparam int E_W = 5 * COORD_BITS + 3;
    localparam int PW  = COORD_BITS + FRAC_BITS + 2;

    logic [SCREEN_W-1:0] r_screen_max_x;
    logic [SCREEN_W-1:0] r_screen_max_y;
    logic [QUAD_W-1:0]   r_quad;

    logic                q_valid;
    logic                q_pop;
    logic [E_W-1:0]      q_data;
    t_emit_req           emit_req;
    logic                emit_take;
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_max_x <= SCREEN_MAX_RST;
            r_screen_max_y <= SCREEN_MAX_RST;
            r_quad         <= QUAD_1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SCREEN_MAX_X: r_screen_max_x <= i_cfg_data[SCREEN_W-1:0];
                CFG_SCREEN_MAX_Y: r_screen_max_y <= i_cfg_data[SCREEN_W-1:0];
                CFG_QUADRANT:     r_quad         <= i_cfg_data[QUAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dlr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_data  (q_data)
    );

    dlr_engine #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_data    (q_data),
        .o_emit      (emit_req),
        .i_emit_take (emit_take),
        .o_pos_x     (pos_x),
        .o_pos_y     (pos_y)
    );

    dlr_emit #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_emit         (emit_req),
        .o_emit_take    (emit_take),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_screen_max_x (r_screen_max_x),
        .i_screen_max_y (r_screen_max_y),
        .i_quad         (r_quad),
        .o_pix          (o_pix)
    );

endmodule

[rtl/core/dlr_chk.sv]
// ----------------------------------------------------------------------------
// dlr_chk
// Port-level checks of the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_core_assert.svh"

module dlr_chk #(
    parameter int COORD_BITS = 10
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  i_in_ready,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS+1:0] i_pixel_x,
    input logic [COORD_BITS+1:0] i_pixel_y,
    input logic                  i_valid_res,
    input logic                  i_last
);
    logic       in_fire;
    logic       out_fire;
    logic [3:0] r_outstanding;
    logic [3:0] n_outstanding;

    assign in_fire  = i_in_valid && i_in_ready;
    assign out_fire = i_out_valid && i_out_ready;

    // commands accepted but not yet answered
    always_comb begin
        n_outstanding = r_outstanding;
        case ({in_fire, out_fire})
            2'b10:   n_outstanding = r_outstanding + 4'd1;
            2'b01:   n_outstanding = r_outstanding - 4'd1;
            default: n_outstanding = r_outstanding;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= 4'd0;
        end else begin
            r_outstanding <= n_outstanding;
        end
    end

    `DLR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_pixel_x) && $stable(i_pixel_y) && $stable(i_valid_res) && $stable(i_last))
    `DLR_ASSERT_IMPL(a_idle_zero, i_clk, i_rst_n, i_out_valid && !i_valid_res, i_pixel_x == '0 && i_pixel_y == '0 && !i_last)
    `DLR_ASSERT_IMPL(a_no_orphan, i_clk, i_rst_n, i_out_valid, r_outstanding != 4'd0)
    `DLR_ASSERT_IMPL(a_depth, i_clk, i_rst_n, in_fire, r_outstanding <= 4'd3)

endmodule

bind dda_line_rasterizer_core dlr_chk #(
    .COORD_BITS (COORD_BITS)
) u_dlr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_pixel_x   (o_pix.pixel_x),
    .i_pixel_y   (o_pix.pixel_y),
    .i_valid_res (o_pix.valid_res),
    .i_last      (o_pix.last)
);

[tb/tb_dda_line_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer_core
// Self-checking bench for the DDA line rasterizer. Start and advance commands
// are pushed through the command channel. A local line model predicts every
// pixel transaction, and each transaction on the pixel channel is compared
// field by field with the oldest prediction. Directed lines, a sweep of view
// settings and four random phases with different sender and receiver idling
// run in turn.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer_core;
    import dlr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD          = 10;
    localparam int FRAC           = 16;
    localparam int PHASE_ITEMS    = 365;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 4000;

    // Index past the last register; the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic            op;
        logic [COORD-1:0] xs;
        logic [COORD-1:0] ys;
        logic [COORD-1:0] xe;
        logic [COORD-1:0] ye;
    } t_line_cmd;

    typedef struct packed {
        logic [COORD+1:0] pixel_x;
        logic [COORD+1:0] pixel_y;
        logic             valid_res;
        logic             last;
    } t_pixel;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dlr_cmd_if #(.COORD_BITS(COORD)) cmd ();
    dlr_pix_if #(.COORD_BITS(COORD)) pix ();

    dda_line_rasterizer_core #(
        .COORD_BITS(COORD),
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_cmd     (cmd),
        .o_pix     (pix)
    );

    // Line model state and its copy of the registers
    logic signed [27:0] ln_pos_x;
    logic signed [27:0] ln_pos_y;
    logic signed [17:0] ln_inc_x;
    logic signed [17:0] ln_inc_y;
    logic [10:0]        ln_steps_left;
    logic               ln_active;
    logic [9:0]         cfg_max_x;
    logic [9:0]         cfg_max_y;
    logic [2:0]         cfg_quad;

    t_pixel      pending_pixels[$];
    int          error_count;
    int          send_idle_pct;
    int          stall_pct;
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Line model
    // ------------------------------------------------------------------
    function automatic logic signed [17:0] axis_increment(input logic neg,
                                                          input logic [10:0] mag,
                                                          input logic [10:0] span);
        logic [26:0] num;
        logic [17:0] q;
        num = {mag, 16'h0000};
        q   = 18'(num / span);
        return neg ? -$signed(q) : $signed(q);
    endfunction

    // Round half away from zero, mirror, then offset by half the screen
    function automatic logic [COORD+1:0] screen_coord(input logic signed [27:0] pos,
                                                      input logic [9:0] smax,
                                                      input logic neg);
        logic [27:0]        mag;
        logic signed [12:0] r;
        logic signed [12:0] sum;
        mag = pos[27] ? 28'(-pos) : 28'(pos);
        r   = 13'((mag + 28'(1 << (FRAC - 1))) >> FRAC);
        if (neg ^ pos[27])
            r = -r;
        sum = $signed({3'b000, smax[9:1]}) + r;
        return sum[COORD+1:0];
    endfunction

    function automatic t_pixel place_pixel(input logic is_last);
        t_pixel px;
        logic   neg_x;
        logic   neg_y;
        case (cfg_quad)
            QUAD_2:  {neg_x, neg_y} = 2'b11;
            QUAD_3:  {neg_x, neg_y} = 2'b10;
            QUAD_4:  {neg_x, neg_y} = 2'b00;
            default: {neg_x, neg_y} = 2'b01;
        endcase
        px.pixel_x   = screen_coord(ln_pos_x, cfg_max_x, neg_x);
        px.pixel_y   = screen_coord(ln_pos_y, cfg_max_y, neg_y);
        px.valid_res = 1'b1;
        px.last      = is_last;
        return px;
    endfunction

    function automatic t_pixel rasterize(input t_line_cmd c);
        t_pixel             px;
        logic signed [10:0] dx;
        logic signed [10:0] dy;
        logic [10:0]        adx;
        logic [10:0]        ady;
        logic [10:0]        span;
        px = '0;
        if (c.op == OP_START) begin
            dx   = {c.xe[9], c.xe} - {c.xs[9], c.xs};
            dy   = {c.ye[9], c.ye} - {c.ys[9], c.ys};
            adx  = dx[10] ? 11'(-dx) : 11'(dx);
            ady  = dy[10] ? 11'(-dy) : 11'(dy);
            span = (adx > ady) ? adx : ady;
            ln_pos_x = {{2{c.xs[9]}}, c.xs, 16'h0000};
            ln_pos_y = {{2{c.ys[9]}}, c.ys, 16'h0000};
            if (span == 11'd0) begin
                ln_inc_x = '0;
                ln_inc_y = '0;
            end else begin
                ln_inc_x = axis_increment(dx[10], adx, span);
                ln_inc_y = axis_increment(dy[10], ady, span);
            end
            ln_steps_left = span;
            ln_active     = (span != 11'd0);
            px = place_pixel(span == 11'd0);
        end else if (ln_active) begin
            ln_pos_x      = ln_pos_x + ln_inc_x;
            ln_pos_y      = ln_pos_y + ln_inc_y;
            ln_steps_left = ln_steps_left - 11'd1;
            if (ln_steps_left == 11'd0)
                ln_active = 1'b0;
            px = place_pixel(ln_steps_left == 11'd0);
        end
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_line_cmd random_cmd(input logic op);
        t_line_cmd c;
        c.op = op;
        c.xs = 10'($urandom);
        c.ys = 10'($urandom);
        c.xe = 10'($urandom);
        c.ye = 10'($urandom);
        return c;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > 511)
            return 511;
        if (v < -512)
            return -512;
        return v;
    endfunction

    task automatic send_cmd(input t_line_cmd c);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd.valid   <= 1'b1;
        cmd.op      <= c.op;
        cmd.x_start <= c.xs;
        cmd.y_start <= c.ys;
        cmd.x_end   <= c.xe;
        cmd.y_end   <= c.ye;
        @(posedge i_clk);
        while (!cmd.ready)
            @(posedge i_clk);
        pending_pixels.push_back(rasterize(c));
    endtask

    task automatic start_line(input logic signed [9:0] xs, input logic signed [9:0] ys,
                              input logic signed [9:0] xe, input logic signed [9:0] ye);
        t_line_cmd c;
        c.op = OP_START;
        c.xs = xs;
        c.ys = ys;
        c.xe = xe;
        c.ye = ye;
        send_cmd(c);
    endtask

    task automatic advance(input int n);
        repeat (n) send_cmd(random_cmd(OP_STEP));
    endtask

    // Drop valid and hold until every pixel is back and the engine is quiet
    task automatic settle();
        cmd.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_view(input logic [9:0] mx, input logic [9:0] my,
                                input logic [9:0] quad_word, input bit poke_unused);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SCREEN_MAX_X;
        i_cfg_data <= mx;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SCREEN_MAX_Y;
        i_cfg_data <= my;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_QUADRANT;
        i_cfg_data <= quad_word;
        @(posedge i_clk);
        if (poke_unused) begin
            i_cfg_idx  <= CFG_UNUSED;
            i_cfg_data <= 10'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        cfg_max_x = mx;
        cfg_max_y = my;
        cfg_quad  = quad_word[2:0];
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_lines();
        send_idle_pct = 0;
        stall_pct     = 0;
        advance(1);                         // idle advance right after reset
        start_line(-512, 511, -512, 511);   // zero length
        advance(1);
        start_line(0, 0, 3, -2);
        advance(4);                         // runs one past the endpoint
        start_line(-512, -512, 511, 511);   // full span
        advance(2);
        start_line(511, -512, 509, -511);   // abandons the open line
        advance(2);
        start_line(5, 0, 5, 2);             // vertical
        advance(2);
        start_line(0, 0, 2, 1);             // y lands on exact halves
        advance(2);
        start_line(0, 0, -2, -1);           // negative halves round away
        advance(2);
    endtask

    task automatic test_view_settings();
        logic [9:0] mx;
        logic [9:0] my;
        logic [9:0] qword;
        for (int q = 0; q <= 8; q++) begin
            settle();
            mx    = (q % 3 == 0) ? 10'd1023 : ((q % 3 == 1) ? 10'd0 : 10'($urandom));
            my    = (q % 3 == 2) ? 10'd1023 : ((q % 3 == 0) ? 10'd0 : 10'($urandom));
            // last pass puts junk in the upper data bits of the quadrant write
            qword = (q < 8) ? 10'(q) : 10'h3FC;
            program_view(mx, my, qword, q[0]);
            start_line(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
            advance(1);
        end
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct,
                                     input logic [9:0] mx, input logic [9:0] my,
                                     input bit pressure);
        int sent;
        int pick;
        int span;
        int xs;
        int ys;
        int xe;
        int ye;
        int count;
        bit paused;
        settle();
        program_view(mx, my, 10'($urandom), 1'($urandom_range(1)));
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        sent   = 0;
        paused = 0;
        while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_cmd(random_cmd(1'($urandom_range(1))));
                sent++;
            end else begin
                pick = $urandom_range(99);
                span = (pick < 85) ? 15 : ((pick < 95) ? 64 : 1023);
                xs   = $signed(10'($urandom));
                ys   = $signed(10'($urandom));
                xe   = clamp_coord(xs + int'($urandom_range(0, 2 * span)) - span);
                ye   = clamp_coord(ys + int'($urandom_range(0, 2 * span)) - span);
                start_line(10'(xs), 10'(ys), 10'(xe), 10'(ye));
                count = int'(ln_steps_left);
                pick  = $urandom_range(99);
                if (pick >= 90)
                    count = count + int'($urandom_range(1, 2));
                else if (pick >= 75)
                    count = int'($urandom_range(0, count));
                // keep the phase close to its item budget
                if (sent + 1 + count > PHASE_ITEMS)
                    count = PHASE_ITEMS - sent - 1;
                advance(count);
                sent = sent + 1 + count;
            end
            if (pressure && !paused && sent >= PHASE_ITEMS / 2) begin
                settle();
                paused = 1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker, watchdog
    // ------------------------------------------------------------------
    initial begin
        pix.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            pix.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && pix.valid && pix.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("pixel transaction with no prediction waiting");
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (pix.pixel_x !== want.pixel_x) begin
                    $error("pixel_x mismatch: expected %0d, actual %0d",
                           $signed(want.pixel_x), $signed(pix.pixel_x));
                    error_count++;
                end
                if (pix.pixel_y !== want.pixel_y) begin
                    $error("pixel_y mismatch: expected %0d, actual %0d",
                           $signed(want.pixel_y), $signed(pix.pixel_y));
                    error_count++;
                end
                if (pix.valid_res !== want.valid_res) begin
                    $error("valid_res mismatch: expected %0b, actual %0b",
                           want.valid_res, pix.valid_res);
                    error_count++;
                end
                if (pix.last !== want.last) begin
                    $error("last mismatch: expected %0b, actual %0b", want.last, pix.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cmd.valid && cmd.ready) || (pix.valid && pix.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_SCREEN_MAX_X;
        i_cfg_data  <= '0;
        cmd.valid   <= 1'b0;
        cmd.op      <= OP_STEP;
        cmd.x_start <= '0;
        cmd.y_start <= '0;
        cmd.x_end   <= '0;
        cmd.y_end   <= '0;
        quiet_cycles  = 0;
        error_count   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        cfg_max_x     = SCREEN_MAX_RST;
        cfg_max_y     = SCREEN_MAX_RST;
        cfg_quad      = QUAD_1;
        ln_pos_x      = '0;
        ln_pos_y      = '0;
        ln_inc_x      = '0;
        ln_inc_y      = '0;
        ln_steps_left = '0;
        ln_active     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_lines();
        test_view_settings();
        test_random_phase(0, 0, 10'd1023, 10'd1023, 1'b0);
        test_random_phase(45, 0, 10'd0, 10'd0, 1'b1);
        test_random_phase(0, 45, 10'($urandom), 10'($urandom), 1'b0);
        test_random_phase(34, 34, 10'($urandom), 10'($urandom), 1'b0);
        settle();

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
